[src/set_assoc_lru_cache_tags_defines.svh]
// Assertion macros for the LRU cache tag store.
// Needs clk and rst_n in the scope of each use.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH

`ifndef SYNTH
`define SLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slc assertion failed");
`define SLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slc assertion failed");
`else
`define SLC_ASSERT_IMP(lbl, ante, cons)
`define SLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/slc_pkg.sv]
// Shared constants and types of the LRU cache tag store.
// No dependencies.
`timescale 1ns / 1ps

package slc_pkg;

  localparam int WAYS         = 4;
  localparam int INDEX_BITS   = 8;
  localparam int OFFSET_BITS  = 5;
  localparam int ADDR_BITS    = 32;
  localparam int TAG_BITS     = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
  localparam int STAMP_BITS   = 32;
  localparam int SETS         = 1 << INDEX_BITS;
  localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_OUT_BITS = 2;

  typedef struct packed {
    logic                  valid;
    logic                  dirty;
    logic [TAG_BITS-1:0]   tag;
    logic [STAMP_BITS-1:0] stamp;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_BITS = $bits(row_t);

  // running state of the per-way scan
  typedef struct packed {
    logic                  hit_found;
    logic [WAY_BITS-1:0]   hit_way;
    logic                  inv_found;
    logic [WAY_BITS-1:0]   inv_way;
    logic [WAY_BITS-1:0]   lru_way;
    logic [STAMP_BITS-1:0] lru_stamp;
  } scan_t;

  typedef struct packed {
    logic                    hit;
    logic [WAY_OUT_BITS-1:0] way;
    logic                    evicted;
    logic                    writeback;
  } result_t;

endpackage

[src/slc_in_if.sv]
// Access channel: valid/ready plus access kind and byte address.
// Depends on slc_pkg.
`timescale 1ns / 1ps

interface slc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [slc_pkg::ADDR_BITS-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink   (input valid, input kind, input address, output ready);
endinterface

[src/slc_out_if.sv]
// Result channel: valid/ready plus hit, way, evicted and writeback.
// Depends on slc_pkg.
`timescale 1ns / 1ps

interface slc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [slc_pkg::WAY_OUT_BITS-1:0] way;
  logic                             evicted;
  logic                             writeback;

  modport source (output valid, output hit, output way, output evicted,
                  output writeback, input ready);
  modport sink   (input valid, input hit, input way, input evicted,
                  input writeback, output ready);
endinterface

[src/set_assoc_lru_cache_tags.sv]
// Tag/state store of a 4-way set-associative write-back cache, LRU by stamps.
// A set row is read from the tag RAM, its ways go one per cycle through the
// shared scan step, then the row is written back and the result registered.
// A new access is taken only when idle, after the previous row is written
// back, which waits for an unread result. Synchronous active-low reset clears
// the access clock and per-set valid flags; the tag RAM itself is not cleared.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_tags_defines.svh"

module set_assoc_lru_cache_tags (
  input  logic            clk,
  input  logic            rst_n,
  slc_in_if.sink          in_ch,
  slc_out_if.source       out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                               state_r, state_nxt;
  logic [slc_pkg::WAY_BITS-1:0]         way_cnt_r;
  logic                                 kind_r;
  logic [slc_pkg::INDEX_BITS-1:0]       set_r;
  logic [slc_pkg::TAG_BITS-1:0]         tag_r;
  logic [slc_pkg::STAMP_BITS-1:0]       clk_r;
  logic                                 row_ok_r;
  logic [slc_pkg::SETS-1:0]             row_vld_r;
  slc_pkg::scan_t                       scan_r, scan_nxt;
  logic                                 out_valid_r;
  slc_pkg::result_t                     res_r, res_nxt;

  logic                                 in_acc;
  logic                                 done_go;
  logic [slc_pkg::INDEX_BITS-1:0]       in_set;
  logic [slc_pkg::ROW_BITS-1:0]         rd_data;
  slc_pkg::row_t                        row_q, row_m, row_new;
  logic [slc_pkg::WAY_BITS-1:0]         sel;
  logic                                 evict;

  assign in_set  = in_ch.address[slc_pkg::OFFSET_BITS +: slc_pkg::INDEX_BITS];
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign done_go = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_IDLE);

  slc_ram #(
    .WIDTH (slc_pkg::ROW_BITS),
    .DEPTH (slc_pkg::SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (done_go),
    .wr_addr (set_r),
    .wr_data (row_new),
    .rd_en   (in_acc),
    .rd_addr (in_set),
    .rd_data (rd_data)
  );

  assign row_q = slc_pkg::row_t'(rd_data);

  // a set never written since reset reads as all ways invalid and clean
  always_comb begin
    row_m = row_q;
    for (int w = 0; w < slc_pkg::WAYS; w++) begin
      if (!row_ok_r) begin
        row_m[w].valid = 1'b0;
        row_m[w].dirty = 1'b0;
      end
    end
  end

  slc_step u_step (
    .way      (way_cnt_r),
    .line     (row_m[way_cnt_r]),
    .tag      (tag_r),
    .scan_in  (scan_r),
    .scan_out (scan_nxt)
  );

  // pick the way and build the updated row
  always_comb begin
    sel   = scan_r.lru_way;
    evict = 1'b1;
    if (scan_r.hit_found) begin
      sel   = scan_r.hit_way;
      evict = 1'b0;
    end else if (scan_r.inv_found) begin
      sel   = scan_r.inv_way;
      evict = 1'b0;
    end
    row_new = row_m;
    if (scan_r.hit_found) begin
      row_new[sel].stamp = clk_r;
      row_new[sel].dirty = row_m[sel].dirty | kind_r;
    end else begin
      row_new[sel].valid = 1'b1;
      row_new[sel].dirty = kind_r;
      row_new[sel].tag   = tag_r;
      row_new[sel].stamp = clk_r;
    end
    res_nxt.hit       = scan_r.hit_found;
    res_nxt.way       = slc_pkg::WAY_OUT_BITS'(sel);
    res_nxt.evicted   = evict;
    res_nxt.writeback = evict && row_m[sel].dirty;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (way_cnt_r == slc_pkg::WAY_BITS'(slc_pkg::WAYS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      way_cnt_r   <= '0;
      clk_r       <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        way_cnt_r <= '0;
        clk_r     <= clk_r + 1'b1;
      end else if (state_r == ST_SCAN) begin
        way_cnt_r <= way_cnt_r + 1'b1;
      end
      if (done_go) begin
        row_vld_r[set_r] <= 1'b1;
        out_valid_r      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= in_ch.kind;
      set_r    <= in_set;
      tag_r    <= in_ch.address[slc_pkg::ADDR_BITS-1 -: slc_pkg::TAG_BITS];
      row_ok_r <= row_vld_r[in_set];
      scan_r   <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_r <= scan_nxt;
    end
    if (done_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = res_r.hit;
  assign out_ch.way       = res_r.way;
  assign out_ch.evicted   = res_r.evicted;
  assign out_ch.writeback = res_r.writeback;

  `SLC_ASSERT_NEXT(a_acc_starts_scan, in_acc, state_r == ST_SCAN && way_cnt_r == '0)
  `SLC_ASSERT_NEXT(a_clock_advances, in_acc, clk_r == $past(clk_r) + 1'b1)
  `SLC_ASSERT_IMP(a_hit_no_evict, out_valid_r && res_r.hit, !res_r.evicted)
  `SLC_ASSERT_IMP(a_wb_needs_evict, out_valid_r && res_r.writeback, res_r.evicted)
  `SLC_ASSERT_NEXT(a_done_sets_row, done_go, row_vld_r[$past(set_r)] && out_valid_r)

endmodule

[src/slc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/slc_step.sv]
// One scan step over a single way: tag match, first invalid, oldest stamp.
// Depends on slc_pkg.
`timescale 1ns / 1ps

module slc_step (
  input  logic [slc_pkg::WAY_BITS-1:0] way,
  input  slc_pkg::line_t               line,
  input  logic [slc_pkg::TAG_BITS-1:0] tag,
  input  slc_pkg::scan_t               scan_in,
  output slc_pkg::scan_t               scan_out
);

  logic match;
  logic older;

  assign match = line.valid && (line.tag == tag);
  // way 0 seeds the minimum; later ways replace only on strictly smaller
  assign older = (way == '0) || (line.stamp < scan_in.lru_stamp);

  always_comb begin
    scan_out = scan_in;
    if (match && !scan_in.hit_found) begin
      scan_out.hit_found = 1'b1;
      scan_out.hit_way   = way;
    end
    if (!line.valid && !scan_in.inv_found) begin
      scan_out.inv_found = 1'b1;
      scan_out.inv_way   = way;
    end
    if (older) begin
      scan_out.lru_way   = way;
      scan_out.lru_stamp = line.stamp;
    end
  end

endmodule
